### src/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication on the same edge
`define CHK_IMPL(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// implication on the next edge
`define CHK_NEXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

### src/ngcl_pkg.sv
// ----------------------------------------------------------------------------
// ngcl_pkg
// Shared types and constants of the non-uniform grid cell locator.
// ----------------------------------------------------------------------------
package ngcl_pkg;
	localparam logic [1:0] REQ_WRITE  = 2'd0;
	localparam logic [1:0] REQ_LOCATE = 2'd1;
	localparam logic [1:0] REQ_NODE   = 2'd2;

	localparam logic [2:0] CFG_ORG_X = 3'd0;
	localparam logic [2:0] CFG_ORG_Y = 3'd1;
	localparam logic [2:0] CFG_ORG_Z = 3'd2;
	localparam logic [2:0] CFG_CNT_X = 3'd3;
	localparam logic [2:0] CFG_CNT_Y = 3'd4;
	localparam logic [2:0] CFG_CNT_Z = 3'd5;
	localparam logic [2:0] CFG_TOL   = 3'd6;

	localparam int IN_BITS  = 160;
	localparam int OUT_BITS = 176;

	localparam logic [16:0] FRAC_ONE = 17'h10000;

	// command from sequencer to divider
	typedef struct packed {
		logic        start;
		logic [33:0] num;
		logic [30:0] den;
	} div_cmd_t;

	typedef struct packed {
		logic        done;
		logic [16:0] quo;
	} div_rsp_t;
endpackage

### src/ngcl_div.sv
// ----------------------------------------------------------------------------
// ngcl_div
// Restoring divider, one quotient bit a cycle: floor(num * 65536 / den).
// ----------------------------------------------------------------------------
module ngcl_div import ngcl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_cmd_t cmd,
	output div_rsp_t rsp
);
	logic [32:0] rem_q;
	logic [30:0] den_q;
	logic [16:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [33:0] sh;

	assign sh    = {rem_q, 1'b0};
	assign trial = sh[32:0] - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
				rem_q  <= cmd.num[32:0];
				den_q  <= cmd.den;
				quo_q  <= '0;
			end else if (busy_q) begin
				if (sh[33:0] >= {3'b0, den_q}) begin
					rem_q <= trial;
					quo_q <= {quo_q[15:0], 1'b1};
				end else begin
					rem_q <= sh[32:0];
					quo_q <= {quo_q[15:0], 1'b0};
				end
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	assign rsp = '{done: done_q, quo: quo_q};
endmodule

### src/ngcl_wmem.sv
// ----------------------------------------------------------------------------
// ngcl_wmem
// Width table of one axis: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ngcl_wmem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [30:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [30:0]   rdata
);
	logic [30:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### src/nonuniform_grid_cell_locate.sv
// ----------------------------------------------------------------------------
// nonuniform_grid_cell_locate
// Locates points in a 3D rectilinear grid with per-axis width tables.
// ----------------------------------------------------------------------------
// Write: accepted in idle; the block stays ready. Locate, per axis: walks the
// width table and stops below the grid, at the cell holding the point (with a
// division for the fraction) or past the end. Node, per axis: origin plus the
// widths below node g. One word in flight; next accepted after result.
// Reset idles control; config goes to origin 0, count 1, tolerance 1; width tables are not cleared.
module nonuniform_grid_cell_locate import ngcl_pkg::*; #(
	parameter int MAX_CELLS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// req_type, axis_sel, cell_slot, width_value, point_x/y/z, node_x/y/z
	input  logic [IN_BITS-1:0]   s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// index_x/y/z, frac_x/y/z, inside_res, node_pos_x/y/z
	output logic [OUT_BITS-1:0]  m_axis_tdata,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_addr,
	input  logic [31:0]          cfg_wdata
);
	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int CW = $clog2(MAX_CELLS + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_AXIS, ST_WALK, ST_DIV, ST_OUT
	} state_t;

	state_t state_q;
	logic signed [31:0] org_q [3];
	logic [6:0]  cnt_q [3];
	logic [15:0] tol_q;

	logic [1:0]  req_q;
	logic [1:0]  ax_q;
	logic signed [31:0] pt_q [3];
	logic [6:0]  nd_q [3];
	logic [CW-1:0] c_q;
	logic [CW-1:0] lim_q;
	logic signed [38:0] off_q;
	logic        rd_ok_q;
	logic signed [7:0]  idx_q [3];
	logic [16:0] frac_q [3];
	logic signed [31:0] pos_q [3];
	logic        ovalid_q;
	logic        div_start_q;
	logic        div_pend_q;

	logic [1:0]  in_req, in_ax;
	logic [5:0]  in_slot;
	logic [30:0] in_w;
	assign in_req  = s_axis_tdata[1:0];
	assign in_ax   = s_axis_tdata[3:2];
	assign in_slot = s_axis_tdata[9:4];
	assign in_w    = s_axis_tdata[40:10];

	logic [30:0] rd [3];
	logic [AW-1:0] raddr;
	logic          wr_ok;
	assign raddr = c_q[AW-1:0];
	assign wr_ok = (state_q == ST_IDLE) && s_axis_tvalid && (in_req == REQ_WRITE)
		&& ({26'b0, in_slot} < 32'(MAX_CELLS));

	for (genvar a = 0; a < 3; a++) begin : g_mem
		ngcl_wmem #(.DEPTH(MAX_CELLS), .AW(AW)) u_mem (
			.clk(clk), .we(wr_ok && in_ax == 2'(a)), .waddr(in_slot[AW-1:0]),
			.wdata(in_w), .raddr(raddr), .rdata(rd[a]));
	end

	div_cmd_t dcmd;
	div_rsp_t drsp;
	ngcl_div u_div (.clk(clk), .arst_n(arst_n), .cmd(dcmd), .rsp(drsp));

	// effective count for current axis
	logic [6:0]  cnt_raw;
	logic [CW-1:0] n_eff;
	logic signed [38:0] eps, w_cur, base;
	assign cnt_raw = cnt_q[ax_q];
	always_comb begin
		if (cnt_raw == 7'd0) n_eff = CW'(1);
		else if (32'(cnt_raw) > 32'(MAX_CELLS)) n_eff = CW'(MAX_CELLS);
		else n_eff = CW'(cnt_raw);
	end
	assign eps   = 39'(tol_q);
	assign w_cur = {8'b0, rd[ax_q]};
	assign base  = 39'(org_q[ax_q]);

	logic signed [38:0] pt_off;
	assign pt_off = 39'(pt_q[ax_q]) - base;

	logic [CW-1:0] gsat;
	assign gsat = (32'(nd_q[ax_q]) > 32'(n_eff)) ? n_eff : CW'(nd_q[ax_q]);

	logic signed [38:0] sat_hi, sat_lo;
	assign sat_hi = 39'sh7FFFFFFF;
	assign sat_lo = -39'sh80000000;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign dcmd = '{start: div_start_q, num: off_q[33:0], den: rd[ax_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			div_start_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				org_q[i] <= '0;
				cnt_q[i] <= 7'd1;
			end
			tol_q <= 16'd1;
		end else begin
			div_start_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_ORG_X: org_q[0] <= cfg_wdata;
					CFG_ORG_Y: org_q[1] <= cfg_wdata;
					CFG_ORG_Z: org_q[2] <= cfg_wdata;
					CFG_CNT_X: cnt_q[0] <= cfg_wdata[6:0];
					CFG_CNT_Y: cnt_q[1] <= cfg_wdata[6:0];
					CFG_CNT_Z: cnt_q[2] <= cfg_wdata[6:0];
					CFG_TOL:   tol_q    <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						req_q <= in_req;
						ax_q  <= 2'd0;
						pt_q[0] <= s_axis_tdata[72:41];
						pt_q[1] <= s_axis_tdata[104:73];
						pt_q[2] <= s_axis_tdata[136:105];
						nd_q[0] <= s_axis_tdata[143:137];
						nd_q[1] <= s_axis_tdata[150:144];
						nd_q[2] <= s_axis_tdata[157:151];
						if (in_req == REQ_LOCATE || in_req == REQ_NODE) state_q <= ST_AXIS;
					end
				end
				ST_AXIS: begin
					c_q     <= '0;
					rd_ok_q <= 1'b0;
					if (req_q == REQ_LOCATE) begin
						off_q <= pt_off;
						lim_q <= n_eff;
						if (pt_off < -eps) begin
							idx_q[ax_q]  <= -8'sd1;
							frac_q[ax_q] <= '0;
							pos_q[ax_q]  <= '0;
							state_q <= ST_DIV;
						end else state_q <= ST_WALK;
					end else begin
						off_q <= base;
						lim_q <= gsat;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					// rd holds entry c_q when rd_ok_q
					if (!rd_ok_q) begin
						if (c_q == lim_q) begin
							if (req_q == REQ_LOCATE) begin
								if (off_q <= eps && off_q >= -eps) begin
									idx_q[ax_q]  <= 8'(n_eff - CW'(1));
									frac_q[ax_q] <= FRAC_ONE;
								end else begin
									idx_q[ax_q]  <= 8'(n_eff);
									frac_q[ax_q] <= '0;
								end
								pos_q[ax_q] <= '0;
							end else begin
								idx_q[ax_q]  <= '0;
								frac_q[ax_q] <= '0;
								pos_q[ax_q]  <= (off_q > sat_hi) ? 32'h7FFFFFFF :
									(off_q < sat_lo) ? 32'h80000000 : off_q[31:0];
							end
							state_q <= ST_DIV;
						end else rd_ok_q <= 1'b1;
					end else begin
						rd_ok_q <= 1'b0;
						if (req_q == REQ_LOCATE && off_q < w_cur - eps) begin
							idx_q[ax_q] <= 8'(c_q);
							pos_q[ax_q] <= '0;
							if (off_q <= 0) frac_q[ax_q] <= '0;
							else div_start_q <= 1'b1;
							state_q <= ST_DIV;
							lim_q   <= '0;
						end else begin
							off_q <= off_q + ((req_q == REQ_LOCATE) ? -w_cur : w_cur);
							c_q   <= c_q + CW'(1);
						end
					end
				end
				ST_DIV: begin
					// wait for divider when one was started for this axis
					if (!div_start_q) begin
						if (drsp.done) frac_q[ax_q] <= drsp.quo;
						if (drsp.done || !div_pend_q) begin
							if (ax_q == 2'd2) state_q <= ST_OUT;
							else begin
								ax_q <= ax_q + 2'd1;
								state_q <= ST_AXIS;
							end
						end
					end
				end
				ST_OUT: begin
					if (!ovalid_q) ovalid_q <= 1'b1;
					else if (m_axis_tready) begin
						ovalid_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// divider pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_pend_q <= 1'b0;
		else if (div_start_q) div_pend_q <= 1'b1;
		else if (drsp.done) div_pend_q <= 1'b0;
	end

	function automatic logic [CW-1:0] eff_cnt(input logic [6:0] v);
		if (v == 7'd0) return CW'(1);
		if (32'(v) > 32'(MAX_CELLS)) return CW'(MAX_CELLS);
		return CW'(v);
	endfunction

	logic in_grid;
	always_comb begin
		in_grid = (req_q == REQ_LOCATE);
		for (int i = 0; i < 3; i++) begin
			if (idx_q[i] < 0) in_grid = 1'b0;
			if (32'(idx_q[i]) >= 32'(eff_cnt(cnt_q[i]))) in_grid = 1'b0;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {
		4'b0, pos_q[2], pos_q[1], pos_q[0], in_grid,
		frac_q[2], frac_q[1], frac_q[0], idx_q[2], idx_q[1], idx_q[0]};
endmodule

### src/ngcl_checker.sv
// ----------------------------------------------------------------------------
// ngcl_checker
// Port-level checks for the grid cell locator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ngcl_checker import ngcl_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tvalid,
	input logic                s_axis_tready,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [OUT_BITS-1:0] m_axis_tdata
);
	`CHK_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "valid dropped")
	`CHK_IMPL(a_busy, clk, arst_n, m_axis_tvalid, !s_axis_tready, "accept during output")
	`CHK_IMPL(a_pad, clk, arst_n, m_axis_tvalid, m_axis_tdata[OUT_BITS-1:OUT_BITS-4] == 4'd0, "pad")
endmodule

bind nonuniform_grid_cell_locate ngcl_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));

### sim/nonuniform_grid_cell_locate_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nonuniform_grid_cell_locate_tb
// Self-checking bench: fills the width tables, then sends directed and random
// write, locate and node words through three config phases, with random
// backpressure in phases 0-1; compares each result to an internal predictor.
// ----------------------------------------------------------------------------
module nonuniform_grid_cell_locate_tb;
	import ngcl_pkg::*;

	localparam int NCELL = 64;
	localparam int DRAIN = 400;
	localparam longint LIMIT = 3000000;

	typedef struct {
		logic [1:0]  req;
		logic [1:0]  axis;
		logic [5:0]  slot;
		logic [30:0] wval;
		logic [31:0] pt[3];
		logic [6:0]  nd[3];
	} word_t;

	typedef struct {
		logic [7:0]  idx[3];
		logic [16:0] frac[3];
		logic        in_grid;
		logic [31:0] npos[3];
	} grid_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [IN_BITS-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [OUT_BITS-1:0] m_axis_tdata;
	logic cfg_we = 0;
	logic [2:0] cfg_addr = '0;
	logic [31:0] cfg_wdata = '0;

	nonuniform_grid_cell_locate i_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// predictor state
	longint origin[3];
	int unsigned ncnt[3];
	longint tol;
	logic [30:0] wtab[3][NCELL];

	word_t pending[$];
	word_t cur_word;
	grid_res_t expected_res[$];
	int errors = 0;
	int n_loc = 0, n_node = 0, n_wr = 0;
	int sidle = 0, ridle = 0;
	longint cycles = 0;

	function automatic int unsigned eff_cnt(int a);
		int unsigned n;
		n = ncnt[a];
		if (n < 1) n = 1;
		if (n > NCELL) n = NCELL;
		return n;
	endfunction

	function automatic longint prefix(int a, int g);
		longint s;
		s = 0;
		for (int c = 0; c < g; c++) s += longint'(wtab[a][c]);
		return s;
	endfunction

	function automatic void locate(int a, logic [31:0] p, output logic [7:0] idx,
			output logic [16:0] fr);
		longint off, w;
		int unsigned n, c;
		n = eff_cnt(a);
		off = longint'(signed'(p)) - origin[a];
		if (off < -tol) begin
			idx = 8'hFF;
			fr = '0;
			return;
		end
		for (c = 0; c < n; c++) begin
			w = longint'(wtab[a][c]);
			if (off < w - tol) break;
			off -= w;
		end
		if (c == n) begin
			if (off <= tol && off >= -tol) begin
				idx = 8'(n - 1);
				fr = FRAC_ONE;
			end else begin
				idx = 8'(n);
				fr = '0;
			end
			return;
		end
		idx = 8'(c);
		if (off <= 0) fr = '0;
		else fr = 17'((longint'(off) <<< 16) / longint'(wtab[a][c]));
	endfunction

	function automatic void predict_word(word_t wd);
		grid_res_t r;
		longint s;
		int g;
		case (wd.req)
			REQ_WRITE: begin
				n_wr++;
				if (wd.axis < 3) wtab[wd.axis][wd.slot] = wd.wval;
			end
			REQ_LOCATE: begin
				n_loc++;
				r.in_grid = 1;
				for (int a = 0; a < 3; a++) begin
					locate(a, wd.pt[a], r.idx[a], r.frac[a]);
					if (signed'(r.idx[a]) < 0 || int'(signed'(r.idx[a])) >= eff_cnt(a))
						r.in_grid = 0;
					r.npos[a] = '0;
				end
				expected_res.push_back(r);
			end
			REQ_NODE: begin
				n_node++;
				r.in_grid = 0;
				for (int a = 0; a < 3; a++) begin
					g = int'(wd.nd[a]);
					if (g > eff_cnt(a)) g = eff_cnt(a);
					s = origin[a] + prefix(a, g);
					if (s > 64'sd2147483647) s = 64'sd2147483647;
					if (s < -64'sd2147483648) s = -64'sd2147483648;
					r.idx[a] = '0;
					r.frac[a] = '0;
					r.npos[a] = s[31:0];
				end
				expected_res.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function automatic logic [IN_BITS-1:0] pack_word(word_t wd);
		logic [159:0] v;
		v = {2'b0, wd.nd[2], wd.nd[1], wd.nd[0], wd.pt[2], wd.pt[1], wd.pt[0],
			wd.wval, wd.slot, wd.axis, wd.req};
		return v[IN_BITS-1:0];
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) predict_word(cur_word);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending.size() > 0 && $urandom_range(99) >= sidle) begin
					cur_word = pending.pop_front();
					s_axis_tdata <= pack_word(cur_word);
					s_axis_tvalid <= 1;
				end else begin
					s_axis_tvalid <= 0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		grid_res_t e;
		if (!arst_n) begin
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= $urandom_range(99) >= ridle;
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_res.size() == 0) begin
					$error("unexpected result word %h", m_axis_tdata);
					errors++;
				end else begin
					e = expected_res.pop_front();
					for (int a = 0; a < 3; a++) begin
						if (m_axis_tdata[8*a +: 8] !== e.idx[a]) begin
							$error("index[%0d] exp %0d got %0d", a, signed'(e.idx[a]),
								signed'(m_axis_tdata[8*a +: 8]));
							errors++;
						end
						if (m_axis_tdata[24+17*a +: 17] !== e.frac[a]) begin
							$error("frac[%0d] exp %0d got %0d", a, e.frac[a],
								m_axis_tdata[24+17*a +: 17]);
							errors++;
						end
						if (m_axis_tdata[76+32*a +: 32] !== e.npos[a]) begin
							$error("node_pos[%0d] exp %h got %h", a, e.npos[a],
								m_axis_tdata[76+32*a +: 32]);
							errors++;
						end
					end
					if (m_axis_tdata[75] !== e.in_grid) begin
						$error("inside_res exp %0d got %0d", e.in_grid, m_axis_tdata[75]);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		if (addr < CFG_CNT_X) origin[addr] = longint'(signed'(data));
		else if (addr < CFG_TOL) ncnt[addr - CFG_CNT_X] = 32'(data[6:0]);
		else tol = longint'(data[15:0]);
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (pending.size() > 0 || s_axis_tvalid || expected_res.size() > 0
			|| !s_axis_tready)
			@(negedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic word_t blank(logic [1:0] req);
		word_t wd;
		wd.req = req;
		wd.axis = 2'($urandom_range(3));
		wd.slot = 6'($urandom);
		wd.wval = 31'($urandom);
		for (int a = 0; a < 3; a++) begin
			wd.pt[a] = $urandom;
			wd.nd[a] = 7'($urandom);
		end
		return wd;
	endfunction

	function automatic logic [31:0] near_point(int a);
		int unsigned n, c;
		longint b, w;
		n = eff_cnt(a);
		c = $urandom_range(n - 1);
		b = origin[a] + prefix(a, c);
		w = longint'(wtab[a][c]);
		case ($urandom_range(9))
			0: return 32'(b);
			1: return 32'(b - tol);
			2: return 32'(b - tol - 1);
			3: return 32'(b + w - tol - 1);
			4: return 32'(origin[a] + prefix(a, n) + tol);
			5: return 32'(origin[a] + prefix(a, n) + tol + 1);
			6: return 32'(origin[a] - tol - 1);
			7: return $urandom;
			default: return 32'(b + longint'($urandom_range(32'(w))));
		endcase
	endfunction

	function automatic logic [30:0] rand_width();
		case ($urandom_range(9))
			0: return 31'($urandom_range(32'h7FFFFFFF, 1));
			1: return 31'($urandom_range(8, 1));
			default: return 31'($urandom_range(32'h40000, 1));
		endcase
	endfunction

	task automatic add_random(int count);
		word_t wd;
		int k;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(99);
			if (k < 15) begin
				wd = blank(REQ_WRITE);
				wd.wval = rand_width();
			end else if (k < 60) begin
				wd = blank(REQ_LOCATE);
				for (int a = 0; a < 3; a++) wd.pt[a] = near_point(a);
			end else if (k < 95) begin
				wd = blank(REQ_NODE);
				for (int a = 0; a < 3; a++)
					if ($urandom_range(3) != 0) wd.nd[a] = 7'($urandom_range(eff_cnt(a)));
			end else begin
				wd = blank(2'd3);
			end
			pending.push_back(wd);
		end
	endtask

	initial begin
		word_t wd;
		for (int a = 0; a < 3; a++) begin
			origin[a] = 0;
			ncnt[a] = 1;
		end
		tol = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// phase 0: settings, full table fill, directed words
		sidle = 22;
		ridle = 45;
		cfg_write(CFG_ORG_X, 32'h0);
		cfg_write(CFG_ORG_Y, 32'hFFF0_0000);
		cfg_write(CFG_ORG_Z, 32'h0001_8000);
		cfg_write(CFG_CNT_X, 32'd64);
		cfg_write(CFG_CNT_Y, 32'd1);
		cfg_write(CFG_CNT_Z, 32'd37);
		cfg_write(CFG_TOL, 32'd0);
		for (int a = 0; a < 3; a++)
			for (int s = 0; s < NCELL; s++) begin
				wd = blank(REQ_WRITE);
				wd.axis = 2'(a);
				wd.slot = 6'(s);
				wd.wval = 31'($urandom_range(32'h20000, 1));
				pending.push_back(wd);
			end
		wd = blank(REQ_WRITE);
		wd.axis = 2'd3;
		pending.push_back(wd);
		wd = blank(REQ_WRITE);
		wd.axis = 0;
		wd.slot = 6'd63;
		wd.wval = 31'h7FFFFFFF;
		pending.push_back(wd);
		wd = blank(2'd3);
		pending.push_back(wd);
		wait_idle();
		begin
			logic [31:0] pts[6];
			pts = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000,
				32'hFFF0_0000};
			for (int i = 0; i < 6; i++) begin
				wd = blank(REQ_LOCATE);
				for (int a = 0; a < 3; a++) wd.pt[a] = pts[(i + a) % 6];
				pending.push_back(wd);
			end
		end
		for (int i = 0; i < 8; i++) begin
			wd = blank(REQ_LOCATE);
			for (int a = 0; a < 3; a++) wd.pt[a] = near_point(a);
			pending.push_back(wd);
		end
		wd = blank(REQ_NODE);
		wd.nd = '{7'd0, 7'd0, 7'd0};
		pending.push_back(wd);
		wd.nd = '{7'd64, 7'd64, 7'd64};
		pending.push_back(wd);
		wd.nd = '{7'd127, 7'd1, 7'd37};
		pending.push_back(wd);
		add_random(340);
		wait_idle();

		// phase 1: extreme origins, wide tolerance
		sidle = 45;
		ridle = 22;
		cfg_write(CFG_ORG_X, 32'h7FFF_0000);
		cfg_write(CFG_ORG_Y, 32'h8000_0000);
		cfg_write(CFG_ORG_Z, 32'h7FFF_FFFF);
		cfg_write(CFG_CNT_X, 32'd1);
		cfg_write(CFG_CNT_Y, 32'd64);
		cfg_write(CFG_CNT_Z, 32'd64);
		cfg_write(CFG_TOL, 32'd65535);
		add_random(350);
		wait_idle();

		// phase 2: small grids, no stalls
		sidle = 0;
		ridle = 0;
		cfg_write(CFG_ORG_X, 32'hFFFF_8000);
		cfg_write(CFG_ORG_Y, 32'h0000_1234);
		cfg_write(CFG_ORG_Z, 32'h8000_0000);
		cfg_write(CFG_CNT_X, 32'd5);
		cfg_write(CFG_CNT_Y, 32'd2);
		cfg_write(CFG_CNT_Z, 32'd1);
		cfg_write(CFG_TOL, 32'd17);
		add_random(350);
		wait_idle();

		$display("covered %0d width writes, %0d locate and %0d node requests",
			n_wr, n_loc, n_node);
		$display("three config phases with varied backpressure, %0d cycles", cycles);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
